/* rtl/drrip_pkg.sv */
// shared types and constants of the drrip replacement engine
// no dependencies; imported by the front, back and top modules
package drrip_pkg;

    typedef enum logic [1:0] {
        KIND_FOLLOW,
        KIND_SRRIP,
        KIND_BRRIP
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DECAY
    } state_t;

    localparam logic       FUNC_VICTIM  = 1'b0;
    localparam logic       FUNC_UPDATE  = 1'b1;

    localparam logic [1:0] RRPV_NEAR    = 2'd0;
    localparam logic [1:0] RRPV_LONG    = 2'd2;
    localparam logic [1:0] RRPV_DISTANT = 2'd3;
    localparam logic [1:0] DEAD_TOP     = 2'd3;
    localparam logic [1:0] DEAD_ZERO    = 2'd0;

    localparam int IN_DATA_BITS  = 24;
    localparam int OUT_DATA_BITS = 8;
    localparam int DRAW_BITS     = 5;
    localparam int SET_IN_BITS   = 11;
    localparam int WAY_IN_BITS   = 4;
    localparam int WAY_OUT_BITS  = 4;

endpackage

/* rtl/drrip_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module drrip_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/drrip_queue.sv */
// small fifo between the front and back parts
// no dependencies
module drrip_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (32'(count_reg) == DEPTH);
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

endmodule

/* rtl/drrip_front.sv */
// front part: accepts items, wraps indices, classifies the set kind
// depends on drrip_pkg
module drrip_front #(
    parameter int NUM_SETS    = 2048,
    parameter int NUM_WAYS    = 16,
    parameter int LEADER_SETS = 32,
    parameter int ITEM_BITS   = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [drrip_pkg::IN_DATA_BITS-1:0] s_tdata,
    input  logic                              s_tuser,
    output logic                              push,
    output logic [ITEM_BITS-1:0]              push_data,
    input  logic                              q_full
);
    import drrip_pkg::*;

    localparam int SW = $clog2(NUM_SETS);
    localparam int WW = $clog2(NUM_WAYS);

    logic                   busy_reg, busy_next;
    logic [SET_IN_BITS-1:0] set_reg, set_next;
    logic [WW-1:0]          way_reg;
    logic                   func_reg, hit_reg, evict_reg;
    logic [DRAW_BITS-1:0]   draw_reg;
    logic [5:0]             way_mod;
    logic                   set_ok;
    kind_t                  kind;
    logic                   accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy_reg;

    // way wrap over a narrow value, at most seven subtractions
    always_comb
    begin
        way_mod = {2'b00, s_tdata[14:11]};
        for (int k = 0; k < 8; k++)
        begin
            if (32'(way_mod) >= NUM_WAYS)
            begin
                way_mod = way_mod - 6'(NUM_WAYS);
            end
        end
    end

    // set wrap, one subtraction a cycle
    assign set_ok = (32'(set_reg) < NUM_SETS);

    always_comb
    begin
        if (32'(set_reg) < LEADER_SETS)
        begin
            kind = KIND_SRRIP;
        end
        else if (32'(set_reg) < 2 * LEADER_SETS)
        begin
            kind = KIND_BRRIP;
        end
        else
        begin
            kind = KIND_FOLLOW;
        end
    end

    assign push      = busy_reg && set_ok && !q_full;
    assign push_data = {kind, draw_reg, evict_reg, hit_reg, way_reg, SW'(set_reg), func_reg};

    always_comb
    begin
        busy_next = busy_reg;
        set_next  = set_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            set_next  = s_tdata[10:0];
        end
        else if (busy_reg && !set_ok)
        begin
            set_next = set_reg - SET_IN_BITS'(NUM_SETS);
        end
        else if (push)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg <= set_next;
        if (accept)
        begin
            way_reg   <= WW'(way_mod);
            func_reg  <= s_tuser;
            hit_reg   <= s_tdata[15];
            evict_reg <= s_tdata[16];
            draw_reg  <= s_tdata[21:17];
        end
    end

endmodule

/* rtl/drrip_back.sv */
// back part: per-set read-modify-write, decay sweep, clearing pass, result register
// depends on drrip_pkg and drrip_ram
module drrip_back #(
    parameter int NUM_SETS      = 2048,
    parameter int NUM_WAYS      = 16,
    parameter int DECAY_PERIOD  = 4096,
    parameter int SELECTOR_BITS = 10,
    parameter int ITEM_BITS     = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_not_empty,
    input  logic [ITEM_BITS-1:0]               q_data,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [drrip_pkg::WAY_OUT_BITS-1:0] victim_way
);
    import drrip_pkg::*;

    localparam int SW  = $clog2(NUM_SETS);
    localparam int WW  = $clog2(NUM_WAYS);
    localparam int CW  = $clog2(DECAY_PERIOD);
    localparam int RW  = 4 * NUM_WAYS;
    localparam int DO  = 2 * NUM_WAYS;
    localparam logic [SELECTOR_BITS-1:0] SEL_TOP = {SELECTOR_BITS{1'b1}};
    localparam logic [SELECTOR_BITS-1:0] SEL_MID = SEL_TOP >> 1;

    state_t                   state_reg, state_next;
    logic [SW:0]              swp_reg, swp_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [SELECTOR_BITS-1:0] sel_reg, sel_next;
    logic [ITEM_BITS-1:0]     item_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [WAY_OUT_BITS-1:0]  out_way_reg;
    logic                     out_load;
    logic [WAY_OUT_BITS-1:0]  out_way_new;

    logic          wr_en, rd_en;
    logic [SW-1:0] wr_addr, rd_addr;
    logic [RW-1:0] wr_data, rd_data;

    // item fields
    logic          it_func, it_hit, it_evict;
    logic [SW-1:0] it_set;
    logic [WW-1:0] it_way;
    logic [4:0]    it_draw;
    logic [1:0]    it_kind;

    assign {it_kind, it_draw, it_evict, it_hit, it_way, it_set, it_func} = item_reg;

    drrip_ram #(
        .WIDTH(RW),
        .DEPTH(NUM_SETS)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // row images
    logic [RW-1:0] init_row, decay_row, aged_row, upd_row;
    logic          found3, found2;
    logic [WW-1:0] idx3, idx2, vic_idx;
    logic [1:0]    cur_dead, new_rrpv, new_dead, brrip_ins;
    logic          train;

    always_comb
    begin
        init_row = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            init_row[2*w +: 2] = RRPV_DISTANT;
        end
    end

    always_comb
    begin
        decay_row = rd_data;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (rd_data[DO + 2*w +: 2] != DEAD_ZERO)
            begin
                decay_row[DO + 2*w +: 2] = rd_data[DO + 2*w +: 2] - 2'd1;
            end
        end
    end

    // victim search: first distant way, else first way that ages into distant, else way 0
    always_comb
    begin
        found3   = 1'b0;
        found2   = 1'b0;
        idx3     = '0;
        idx2     = '0;
        aged_row = rd_data;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (rd_data[2*w +: 2] == RRPV_DISTANT)
            begin
                found3 = 1'b1;
                idx3   = WW'(w);
            end
            if (rd_data[2*w +: 2] == RRPV_LONG)
            begin
                found2 = 1'b1;
                idx2   = WW'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (rd_data[2*w +: 2] != RRPV_DISTANT)
            begin
                aged_row[2*w +: 2] = rd_data[2*w +: 2] + 2'd1;
            end
        end
        vic_idx = found3 ? idx3 : (found2 ? idx2 : '0);
    end

    assign out_way_new = WAY_OUT_BITS'(vic_idx);

    // update of one line
    always_comb
    begin
        cur_dead  = rd_data[DO + 2*it_way +: 2];
        brrip_ins = (it_draw == '0) ? RRPV_LONG : RRPV_DISTANT;
        new_dead  = cur_dead;
        train     = 1'b0;
        if (it_hit)
        begin
            new_rrpv = RRPV_NEAR;
            if (cur_dead != DEAD_TOP)
            begin
                new_dead = cur_dead + 2'd1;
            end
        end
        else
        begin
            if (cur_dead == DEAD_ZERO)
            begin
                new_rrpv = RRPV_DISTANT;
            end
            else if (it_kind == KIND_SRRIP)
            begin
                new_rrpv = RRPV_LONG;
            end
            else if (it_kind == KIND_BRRIP)
            begin
                new_rrpv = brrip_ins;
            end
            else
            begin
                new_rrpv = (sel_reg >= SEL_MID) ? RRPV_LONG : brrip_ins;
            end
            if (it_evict && new_rrpv == RRPV_DISTANT)
            begin
                train    = 1'b1;
                new_dead = DEAD_ZERO;
            end
        end
        upd_row = rd_data;
        upd_row[2*it_way +: 2]      = new_rrpv;
        upd_row[DO + 2*it_way +: 2] = new_dead;
    end

    always_comb
    begin
        state_next = state_reg;
        swp_next   = swp_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = it_set;
        wr_data    = upd_row;
        rd_en      = 1'b0;
        rd_addr    = it_set;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = swp_reg[SW-1:0];
                wr_data  = init_row;
                swp_next = swp_reg + 1'b1;
                if (swp_reg == (SW+1)'(NUM_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_READ;
                    if (q_data[0] == FUNC_UPDATE)
                    begin
                        if ({1'b0, cnt_reg} + 1'b1 >= (CW+1)'(DECAY_PERIOD))
                        begin
                            cnt_next   = '0;
                            swp_next   = '0;
                            state_next = ST_DECAY;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
            end
            ST_DECAY:
            begin
                // read row i while writing back the decayed row i-1
                if (swp_reg != (SW+1)'(NUM_SETS))
                begin
                    rd_en   = 1'b1;
                    rd_addr = swp_reg[SW-1:0];
                end
                if (swp_reg != '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = SW'(swp_reg - 1'b1);
                    wr_data = decay_row;
                end
                swp_next = swp_reg + 1'b1;
                if (swp_reg == (SW+1)'(NUM_SETS))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (it_func == FUNC_VICTIM)
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_load   = 1'b1;
                        wr_en      = !found3;
                        wr_data    = aged_row;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    wr_en = 1'b1;
                    if (train && it_kind == KIND_SRRIP && sel_reg != SEL_TOP)
                    begin
                        sel_next = sel_reg + 1'b1;
                    end
                    else if (train && it_kind == KIND_BRRIP && sel_reg != '0)
                    begin
                        sel_next = sel_reg - 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            swp_reg       <= '0;
            cnt_reg       <= '0;
            sel_reg       <= SEL_MID;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            swp_reg       <= swp_next;
            cnt_reg       <= cnt_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_data;
        end
        if (out_load)
        begin
            out_way_reg <= out_way_new;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign victim_way = out_way_reg;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE)
        else $error("queue popped outside idle");
    a_load_victim: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (state_reg == ST_EXEC && it_func == FUNC_VICTIM))
        else $error("result loaded by a non-victim item");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) < DECAY_PERIOD)
        else $error("update count beyond decay period");
    a_decay_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECAY && swp_reg == (SW+1)'(NUM_SETS)) |=> state_reg == ST_READ)
        else $error("decay sweep did not hand over to the read");
`endif

endmodule

/* rtl/drrip_dead_block_replacement_core.sv */
// top level of the drrip replacement engine with dead-block prediction
// depends on drrip_pkg, drrip_front, drrip_queue, drrip_back, drrip_ram
//
// the front registers an accepted item and queues it; the back pops it, reads the set row and
// then loads the result (victim) or writes the row back (update), one item at a time
// an update that completes a decay period first runs a sweep that decays every row
// reset: a clearing pass writes every row before items flow
module drrip_dead_block_replacement_core #(
    parameter int NUM_SETS      = 2048,
    parameter int NUM_WAYS      = 16,
    parameter int DECAY_PERIOD  = 4096,
    parameter int SELECTOR_BITS = 10,
    parameter int LEADER_SETS   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // set_index[10:0], way_index[14:11], was_hit[15], evicted_valid[16],
    // random_draw[21:17], zero fill
    input  logic [drrip_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // func[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // victim_way[3:0], zero fill
    output logic [drrip_pkg::OUT_DATA_BITS-1:0] m_tdata
);
    import drrip_pkg::*;

    localparam int SW = $clog2(NUM_SETS);
    localparam int WW = $clog2(NUM_WAYS);
    // item in the queue: func, set, way, hit, evicted, draw, kind
    localparam int ITEM_BITS = 1 + SW + WW + 1 + 1 + DRAW_BITS + 2;

    logic                    push, q_full, q_pop, q_not_empty;
    logic [ITEM_BITS-1:0]    push_data, q_data;
    logic [WAY_OUT_BITS-1:0] victim_way;

    // front: wraps indices and tags the set as srrip leader, brrip leader or follower
    drrip_front #(
        .NUM_SETS   (NUM_SETS),
        .NUM_WAYS   (NUM_WAYS),
        .LEADER_SETS(LEADER_SETS),
        .ITEM_BITS  (ITEM_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_data(push_data),
        .q_full   (q_full)
    );

    // short queue so the front can still take items during a sweep, until the queue fills
    drrip_queue #(
        .WIDTH(ITEM_BITS),
        .DEPTH(2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .pop_data (q_data)
    );

    // back: line state ram, selector, decay and result register
    drrip_back #(
        .NUM_SETS     (NUM_SETS),
        .NUM_WAYS     (NUM_WAYS),
        .DECAY_PERIOD (DECAY_PERIOD),
        .SELECTOR_BITS(SELECTOR_BITS),
        .ITEM_BITS    (ITEM_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_not_empty(q_not_empty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .victim_way (victim_way)
    );

    assign m_tdata = {{(OUT_DATA_BITS - WAY_OUT_BITS){1'b0}}, victim_way};

endmodule
